@@ hdl/omac_pkg.sv @@
// ----------------------------------------------------------------------------
// omac_pkg
// shared types, codes and helper functions of the motor commander
// ----------------------------------------------------------------------------
package omac_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DEC_DIGITS = 3;  // decimal digits an 8-bit distance can have

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEAR_THRESHOLD = 2'd0,
    REG_DISTANCE_LIMIT = 2'd1,
    REG_STOP_TICKS     = 2'd2,
    REG_TURN_TICKS     = 2'd3
  } cfg_reg_e;

  // transaction kinds
  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_MEASURE = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_e;

  // avoidance sequencer
  typedef enum logic [1:0] {
    AV_IDLE = 2'd0,
    AV_STOP = 2'd1,
    AV_TURN = 2'd2
  } avoid_e;

  // received command characters
  localparam logic [7:0] CHAR_AUTO  = 8'h43;
  localparam logic [7:0] CHAR_STOP  = 8'h51;
  localparam logic [7:0] CHAR_BACK  = 8'h53;
  localparam logic [7:0] CHAR_RIGHT = 8'h44;
  localparam logic [7:0] CHAR_LEFT  = 8'h41;
  localparam logic [7:0] CHAR_FWD   = 8'h57;

  // motor drive codes
  localparam logic [3:0] MOTOR_STOP  = 4'h0;
  localparam logic [3:0] MOTOR_FWD   = 4'hA;
  localparam logic [3:0] MOTOR_BACK  = 4'h5;
  localparam logic [3:0] MOTOR_RIGHT = 4'h9;
  localparam logic [3:0] MOTOR_LEFT  = 4'h6;

  // configuration reset values
  localparam logic [7:0]  NEAR_RST  = 8'd10;
  localparam logic [7:0]  LIMIT_RST = 8'd250;
  localparam logic [15:0] STOP_RST  = 16'd1667;
  localparam logic [15:0] TURN_RST  = 16'd8333;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic       echo_level;
  } omac_in_t;

  typedef struct packed {
    logic [3:0] motor_code;
    logic [7:0] distance;
    logic       auto_on;
    logic       avoid_busy;
    logic [7:0] segment_code;
    logic [3:0] digit_enable;
  } omac_out_t;

  typedef struct packed {
    logic [7:0]  near_threshold;
    logic [7:0]  distance_limit;
    logic [15:0] stop_ticks;
    logic [15:0] turn_ticks;
  } omac_cfg_t;

  // one decoded transaction, applied in the cycle it leaves the input stage
  typedef struct packed {
    logic       rx;
    logic       measure;
    logic       scan;
    logic [7:0] rx_byte;
    logic       echo_level;
  } omac_step_t;

  // echo timer status toward the drive logic
  typedef struct packed {
    logic       fell;
    logic [7:0] distance;  // latched distance after this step
  } omac_echo_t;

  // decimal digits of an 8-bit value, reciprocal multiplies instead of dividers
  function automatic logic [DEC_DIGITS-1:0][3:0] dec_digits(input logic [7:0] d);
    logic [15:0] p10;
    logic [15:0] p100;
    logic [4:0]  q10;
    logic [1:0]  q100;
    logic [7:0]  r0;
    logic [4:0]  r1;
    logic [DEC_DIGITS-1:0][3:0] res;
    p10  = 16'(d) * 16'd205;  // d / 10 for any 8-bit d
    p100 = 16'(d) * 16'd41;   // d / 100 for d below 256
    q10  = p10[15:11];
    q100 = p100[13:12];
    r0   = d - 8'(8'(q10) * 8'd10);
    r1   = q10 - 5'(5'(q100) * 5'd10);
    res[0] = r0[3:0];
    res[1] = r1[3:0];
    res[2] = {2'b00, q100};
    return res;
  endfunction

  // active-low seven-segment patterns
  function automatic logic [7:0] seg_lookup(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0, 4'd10: s = 8'hC0;
      4'd1, 4'd11: s = 8'hF9;
      4'd2, 4'd12: s = 8'hA4;
      4'd3, 4'd13: s = 8'hB0;
      4'd4, 4'd14: s = 8'h99;
      4'd5, 4'd15: s = 8'h92;
      4'd6:        s = 8'h82;
      4'd7:        s = 8'hF8;
      4'd8:        s = 8'h80;
      4'd9:        s = 8'h90;
      default:     s = 8'hFF;
    endcase
    return s;
  endfunction

endpackage

@@ hdl/omac_stream_if.sv @@
// ----------------------------------------------------------------------------
// omac_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
interface omac_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

@@ hdl/omac_cfg.sv @@
// ----------------------------------------------------------------------------
// omac_cfg
// configuration register file, write only
// ----------------------------------------------------------------------------
module omac_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [omac_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [omac_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output omac_pkg::omac_cfg_t                 cfg_o
);
  import omac_pkg::*;

  omac_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_NEAR_THRESHOLD: cfg_d.near_threshold = cfg_data_i[7:0];
        REG_DISTANCE_LIMIT: cfg_d.distance_limit = cfg_data_i[7:0];
        REG_STOP_TICKS:     cfg_d.stop_ticks     = cfg_data_i;
        REG_TURN_TICKS:     cfg_d.turn_ticks     = cfg_data_i;
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.near_threshold <= NEAR_RST;
      cfg_q.distance_limit <= LIMIT_RST;
      cfg_q.stop_ticks     <= STOP_RST;
      cfg_q.turn_ticks     <= TURN_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hdl/omac_echo.sv @@
// ----------------------------------------------------------------------------
// omac_echo
// echo pulse timer, distance latch and decimal digit store
// ----------------------------------------------------------------------------
module omac_echo #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  omac_pkg::omac_step_t                step_i,
  input  logic                                step_en_i,
  input  logic [7:0]                          distance_limit_i,
  output omac_pkg::omac_echo_t                echo_o,
  output logic [7:0]                          distance_o,
  output logic [DIGIT_COUNT-1:0][3:0]         digits_o
);
  import omac_pkg::*;

  logic [7:0] count_q, count_d;
  logic       prev_q, prev_d;
  logic [7:0] dist_q, dist_d;
  logic [DIGIT_COUNT-1:0][3:0] digit_q, digit_d, digit_new;
  logic [7:0] count_inc;
  logic       meas;
  logic       fell;
  logic [DEC_DIGITS-1:0][3:0] dec;

  assign meas = step_en_i && step_i.measure;

  // saturating count of echo-high ticks
  always_comb begin
    if (step_i.echo_level) begin
      if (count_q >= distance_limit_i) count_inc = distance_limit_i;
      else count_inc = count_q + 8'd1;
    end else begin
      count_inc = count_q;
    end
  end

  assign fell = meas && prev_q && !step_i.echo_level;
  assign dec  = dec_digits(count_inc);

  for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
    if (i < DEC_DIGITS) begin : g_dec
      assign digit_new[i] = dec[i];
    end else begin : g_zero
      assign digit_new[i] = 4'd0;
    end
  end

  always_comb begin
    count_d = count_q;
    prev_d  = prev_q;
    dist_d  = dist_q;
    digit_d = digit_q;
    if (meas) begin
      prev_d  = step_i.echo_level;
      count_d = count_inc;
      if (fell) begin
        dist_d  = count_inc;
        digit_d = digit_new;
        count_d = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 8'd0;
      prev_q  <= 1'b0;
      dist_q  <= 8'd0;
      digit_q <= '0;
    end else begin
      count_q <= count_d;
      prev_q  <= prev_d;
      dist_q  <= dist_d;
      digit_q <= digit_d;
    end
  end

  assign echo_o.fell     = fell;
  assign echo_o.distance = dist_d;
  assign distance_o      = dist_q;
  assign digits_o        = digit_q;

endmodule

@@ hdl/omac_drive.sv @@
// ----------------------------------------------------------------------------
// omac_drive
// mode control, manual command decode and avoidance sequencer
// ----------------------------------------------------------------------------
module omac_drive (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  omac_pkg::omac_step_t step_i,
  input  logic                 step_en_i,
  input  omac_pkg::omac_echo_t echo_i,
  input  omac_pkg::omac_cfg_t  cfg_i,
  output logic [3:0]           motor_o,
  output logic                 auto_o,
  output logic                 busy_o
);
  import omac_pkg::*;

  logic        auto_q, auto_d;
  logic [7:0]  byte_q, byte_d;
  logic [3:0]  motor_q, motor_d;
  avoid_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] cnt_inc;
  logic        rx_auto;
  logic        meas;
  logic        far;

  assign rx_auto = step_en_i && step_i.rx && (step_i.rx_byte == CHAR_AUTO);
  assign meas    = step_en_i && step_i.measure;
  assign cnt_inc = cnt_q + 16'd1;
  assign far     = echo_i.distance > cfg_i.near_threshold;

  // mode and stored command
  always_comb begin
    auto_d = auto_q;
    byte_d = byte_q;
    if (step_en_i && step_i.rx) begin
      byte_d = step_i.rx_byte;
    end
    if (rx_auto) begin
      auto_d = !auto_q;
    end
  end

  // sequencer next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    if (rx_auto) begin
      phase_d = AV_IDLE;
      cnt_d   = 16'd0;
    end else if (meas && auto_q) begin
      unique case (phase_q)
        AV_STOP: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.stop_ticks) begin
            phase_d = AV_TURN;
            cnt_d   = 16'd0;
          end
        end
        AV_TURN: begin
          cnt_d = cnt_inc;
          if (cnt_inc >= cfg_i.turn_ticks) begin
            phase_d = AV_IDLE;
            cnt_d   = 16'd0;
          end
        end
        default: begin
          phase_d = AV_IDLE;
          if (echo_i.fell && !far) begin
            phase_d = AV_STOP;
            cnt_d   = 16'd0;
          end
        end
      endcase
    end
  end

  // motor drive output
  always_comb begin
    motor_d = motor_q;
    if (rx_auto) begin
      motor_d = MOTOR_STOP;
    end else if (meas && auto_q) begin
      unique case (phase_q)
        AV_STOP: begin
          if (cnt_inc >= cfg_i.stop_ticks) motor_d = MOTOR_LEFT;
        end
        AV_TURN: begin
          if (cnt_inc >= cfg_i.turn_ticks) motor_d = MOTOR_STOP;
        end
        default: begin
          if (echo_i.fell) motor_d = far ? MOTOR_FWD : MOTOR_STOP;
        end
      endcase
    end else if (meas) begin
      unique case (byte_q)
        CHAR_STOP:  motor_d = MOTOR_STOP;
        CHAR_BACK:  motor_d = MOTOR_BACK;
        CHAR_RIGHT: motor_d = MOTOR_RIGHT;
        CHAR_LEFT:  motor_d = MOTOR_LEFT;
        CHAR_FWD:   motor_d = far ? MOTOR_FWD : MOTOR_STOP;
        default:    motor_d = motor_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q  <= 1'b0;
      byte_q  <= 8'd0;
      motor_q <= MOTOR_STOP;
      phase_q <= AV_IDLE;
      cnt_q   <= 16'd0;
    end else begin
      auto_q  <= auto_d;
      byte_q  <= byte_d;
      motor_q <= motor_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  assign motor_o = motor_q;
  assign auto_o  = auto_q;
  assign busy_o  = (phase_q == AV_STOP) || (phase_q == AV_TURN);

  a_busy_needs_auto: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != AV_IDLE) |-> auto_q)
    else $error("avoidance running in manual mode");

  a_turn_drives_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == AV_TURN) |-> (motor_q == MOTOR_LEFT))
    else $error("turn phase without left drive");

  a_stop_holds_motors: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == AV_STOP) |-> (motor_q == MOTOR_STOP))
    else $error("stop phase with motors running");

endmodule

@@ hdl/omac_scan.sv @@
// ----------------------------------------------------------------------------
// omac_scan
// seven-segment digit scanner and segment decode
// ----------------------------------------------------------------------------
module omac_scan #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  omac_pkg::omac_step_t        step_i,
  input  logic                        step_en_i,
  input  logic [DIGIT_COUNT-1:0][3:0] digits_i,
  output logic [7:0]                  segment_o,
  output logic [3:0]                  digit_en_o
);
  import omac_pkg::*;

  localparam int unsigned IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
  localparam int unsigned EXT_W = (DIGIT_COUNT > 4) ? DIGIT_COUNT : 4;
  localparam logic [DIGIT_COUNT-1:0] TOP_MASK = DIGIT_COUNT'(1) << (DIGIT_COUNT - 1);

  logic [DIGIT_COUNT-1:0] mask_q, mask_d, mask_shift;
  logic [IDX_W-1:0]       idx_q, idx_d;
  logic [IDX_W:0]         idx_inc;
  logic [EXT_W-1:0]       mask_ext;

  assign mask_shift = mask_q >> 1;
  assign idx_inc    = {1'b0, idx_q} + (IDX_W + 1)'(1);

  always_comb begin
    mask_d = mask_q;
    idx_d  = idx_q;
    if (step_en_i && step_i.scan) begin
      if (mask_shift == '0) begin
        mask_d = TOP_MASK;
        idx_d  = '0;
      end else begin
        mask_d = mask_shift;
        if (idx_inc >= (IDX_W + 1)'(DIGIT_COUNT)) idx_d = '0;
        else idx_d = idx_inc[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= TOP_MASK;
      idx_q  <= '0;
    end else begin
      mask_q <= mask_d;
      idx_q  <= idx_d;
    end
  end

  assign mask_ext   = EXT_W'(mask_q);
  assign digit_en_o = ~mask_ext[3:0];
  assign segment_o  = seg_lookup(digits_i[idx_q]);

  a_mask_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(mask_q))
    else $error("scan mask lost its single bit");

  a_mask_tracks_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mask_q == (TOP_MASK >> idx_q))
    else $error("scan mask and digit index disagree");

endmodule

@@ hdl/obstacle_aware_motor_commander.sv @@
// ----------------------------------------------------------------------------
// obstacle_aware_motor_commander
// car motor commander with echo ranging, auto avoidance and digit scan
// ----------------------------------------------------------------------------
// flow: a taken transaction waits in the input register while the result
//   side stalls, then updates the state registers, which offer its result
// throughput: one transaction per cycle unless the result side stalls,
//   set by the state update between the input and state/result registers
// reset: asynchronous, clears mode, echo timer, digits, sequencer and scan;
//   config registers return to their defaults; no clearing pass is needed
module obstacle_aware_motor_commander #(
  parameter int unsigned DIGIT_COUNT = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [omac_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [omac_pkg::CFG_DATA_W-1:0] cfg_data_i,
  omac_stream_if.sink                     cmd_i,
  omac_stream_if.source                   res_o
);
  import omac_pkg::*;

  // input stage: holds one transaction while the result side stalls
  logic       s1_valid_q, s1_valid_d;
  omac_in_t   s1_item_q;
  logic       out_valid_q, out_valid_d;
  logic       advance;
  logic       step_en;
  logic       in_take;
  omac_step_t step;

  omac_cfg_t  cfg;
  omac_echo_t echo;
  logic [7:0] latched_dist;
  logic [DIGIT_COUNT-1:0][3:0] digits;
  logic [3:0] motor;
  logic       auto_on;
  logic       busy;
  logic [7:0] segment;
  logic [3:0] digit_en;

  // the state registers double as the result register, so a transaction
  // moves on only when the result slot is empty or being drained
  assign advance     = !out_valid_q || res_o.ready;
  assign step_en     = s1_valid_q && advance;
  assign cmd_i.ready = !s1_valid_q || advance;
  assign in_take     = cmd_i.valid && cmd_i.ready;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) s1_valid_d = 1'b1;
    else if (advance) s1_valid_d = 1'b0;
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) s1_item_q <= cmd_i.payload;
  end

  // transaction kind decode; the unused code changes nothing
  always_comb begin
    step.rx         = 1'b0;
    step.measure    = 1'b0;
    step.scan       = 1'b0;
    step.rx_byte    = s1_item_q.rx_byte;
    step.echo_level = s1_item_q.echo_level;
    unique case (s1_item_q.command)
      CMD_RX_BYTE: step.rx      = 1'b1;
      CMD_MEASURE: step.measure = 1'b1;
      CMD_DISPLAY: step.scan    = 1'b1;
      default: ;
    endcase
  end

  omac_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // echo timing and distance digits
  omac_echo #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_echo (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .step_en_i        (step_en),
    .distance_limit_i (cfg.distance_limit),
    .echo_o           (echo),
    .distance_o       (latched_dist),
    .digits_o         (digits)
  );

  // mode, manual commands and the stop-then-turn sequence
  omac_drive u_drive (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .step_en_i (step_en),
    .echo_i    (echo),
    .cfg_i     (cfg),
    .motor_o   (motor),
    .auto_o    (auto_on),
    .busy_o    (busy)
  );

  // display multiplexing
  omac_scan #(
    .DIGIT_COUNT (DIGIT_COUNT)
  ) u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .step_en_i  (step_en),
    .digits_i   (digits),
    .segment_o  (segment),
    .digit_en_o (digit_en)
  );

  // result transaction reflects the state after the latest step
  assign res_o.valid                = out_valid_q;
  assign res_o.payload.motor_code   = motor;
  assign res_o.payload.distance     = latched_dist;
  assign res_o.payload.auto_on      = auto_on;
  assign res_o.payload.avoid_busy   = busy;
  assign res_o.payload.segment_code = segment;
  assign res_o.payload.digit_enable = digit_en;

  a_no_step_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_o.ready) |=> $stable(motor) && $stable(auto_on))
    else $error("state moved while the result was stalled");

endmodule
